// ===== src/trlr_pkg.sv =====
// ----------------------------------------------------------------------------
// trlr_pkg: shared types and constants for the tandem repeat run counter
// Item and result structs, configuration register indexes, widths.
// ----------------------------------------------------------------------------
package trlr_pkg;

    localparam int MAX_MOTIF_LEN = 8;
    localparam int NUM_MOTIFS    = 4;
    localparam int COUNT_WIDTH   = 16;

    localparam int SLOTS         = 4;
    localparam int WIN_CHARS     = 8;
    localparam int WIN_W         = WIN_CHARS * 8;
    localparam int MOTIF_W       = 64;
    localparam int LEN_W         = 4;
    localparam int SEEN_W        = 4;
    localparam int SKIP_W        = 3;
    localparam int CFG_W         = 64;

    typedef logic [WIN_W-1:0]       t_window;
    typedef logic [MOTIF_W-1:0]     t_motif;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [SEEN_W-1:0]      t_seen;
    typedef logic [COUNT_WIDTH-1:0] t_run;

    typedef enum logic [2:0] {
        CFG_MOTIF_A  = 3'd0,
        CFG_MOTIF_B  = 3'd1,
        CFG_MOTIF_C  = 3'd2,
        CFG_MOTIF_D  = 3'd3,
        CFG_LENGTH_A = 3'd4,
        CFG_LENGTH_B = 3'd5,
        CFG_LENGTH_C = 3'd6,
        CFG_LENGTH_D = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] base_char;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [15:0] run_a;
        logic [15:0] run_b;
        logic [15:0] run_c;
        logic [15:0] run_d;
    } t_out_item;

    typedef struct packed {
        logic fire;
        logic last;
    } t_lane_ctl;

endpackage

// ===== src/trlr_motif_lane.sv =====
// ----------------------------------------------------------------------------
// trlr_motif_lane: greedy repeat scan for one motif
// Compares the window tail with the motif, tracks skip, run and longest run.
// ----------------------------------------------------------------------------
module trlr_motif_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trlr_pkg::t_lane_ctl i_ctl,
    input  trlr_pkg::t_window  i_window,
    input  trlr_pkg::t_seen    i_seen,
    input  trlr_pkg::t_motif   i_motif,
    input  trlr_pkg::t_len     i_len,
    output trlr_pkg::t_run     o_best_next
);
    import trlr_pkg::*;

    logic [SKIP_W-1:0] r_skip, n_skip;
    t_run              r_cur, n_cur;
    t_run              r_best, n_best;

    t_len              w_len;
    t_len              w_gap;
    t_window           w_aligned;
    logic [WIN_CHARS-1:0] w_hit;
    logic              w_match;

    always_comb begin
        if (i_len == '0) begin
            w_len = LEN_W'(1);
        end else if (i_len > LEN_W'(MAX_MOTIF_LEN)) begin
            w_len = LEN_W'(MAX_MOTIF_LEN);
        end else begin
            w_len = i_len;
        end
    end

    assign w_gap     = LEN_W'(WIN_CHARS) - w_len;
    assign w_aligned = i_window >> {w_gap[2:0], 3'b000};

    always_comb begin
        for (int j = 0; j < WIN_CHARS; j++) begin
            w_hit[j] = (LEN_W'(j) >= w_len) ||
                       (w_aligned[8*j +: 8] == i_motif[8*j +: 8]);
        end
    end

    assign w_match = &w_hit;

    always_comb begin
        n_skip = r_skip;
        n_cur  = r_cur;
        n_best = r_best;
        if (i_ctl.fire && (i_seen >= w_len)) begin
            if (r_skip != '0) begin
                n_skip = r_skip - 1'b1;
            end else if (w_match) begin
                n_cur  = (r_cur == '1) ? r_cur : r_cur + 1'b1;
                n_best = (n_cur > r_best) ? n_cur : r_best;
                n_skip = SKIP_W'(w_len - LEN_W'(1));
            end else begin
                n_cur  = '0;
                n_skip = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.fire && i_ctl.last)) begin
            r_skip <= '0;
            r_cur  <= '0;
            r_best <= '0;
        end else begin
            r_skip <= n_skip;
            r_cur  <= n_cur;
            r_best <= n_best;
        end
    end

    assign o_best_next = n_best;

endmodule

// ===== src/tandem_repeat_longest_run_unit.sv =====
// ----------------------------------------------------------------------------
// tandem_repeat_longest_run_unit: longest tandem repeat run for four motifs
// Streams a sequence one character per transfer and reports per-motif maxima.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall / i_in_data carry one character and
// a last flag per transfer. Output channel: o_out_valid / i_out_stall /
// o_out_data carry the four longest-run counts, one transfer per sequence.
// Configuration: write motifs and lengths through i_cfg_we / i_cfg_index /
// i_cfg_wdata while no sequence is in flight.
// Throughput: one character per cycle unless a last character waits under
// o_in_stall, set by the single compare and update stage between the input
// register and the result register. The result register loads when the last
// character leaves the input register; the result then transfers from there.
// Reset empties the input and result registers, clears the character window
// and all run counters; motifs reset to zero and lengths to one.
// While the result waits under i_out_stall, characters that are not last keep
// streaming; a following last character waits in the input register and
// o_in_stall rises until the result transfers.
// ----------------------------------------------------------------------------
module tandem_repeat_longest_run_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  trlr_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output trlr_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_we,
    input  trlr_pkg::t_cfg_index  i_cfg_index,
    input  logic [trlr_pkg::CFG_W-1:0] i_cfg_wdata
);
    import trlr_pkg::*;

    t_motif    r_motif [SLOTS];
    t_len      r_len   [SLOTS];

    logic      r_in_valid;
    t_in_item  r_in;
    t_window   r_window, n_window;
    t_seen     r_seen, n_seen;
    logic      r_out_valid;
    t_out_item r_out;

    logic      w_out_free;
    logic      w_fire;
    logic      w_accept;
    t_lane_ctl w_ctl;
    t_run      w_best [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_motif[k] <= '0;
                r_len[k]   <= LEN_W'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOTIF_A:  r_motif[0] <= i_cfg_wdata;
                CFG_MOTIF_B:  r_motif[1] <= i_cfg_wdata;
                CFG_MOTIF_C:  r_motif[2] <= i_cfg_wdata;
                CFG_MOTIF_D:  r_motif[3] <= i_cfg_wdata;
                CFG_LENGTH_A: r_len[0]   <= i_cfg_wdata[LEN_W-1:0];
                CFG_LENGTH_B: r_len[1]   <= i_cfg_wdata[LEN_W-1:0];
                CFG_LENGTH_C: r_len[2]   <= i_cfg_wdata[LEN_W-1:0];
                CFG_LENGTH_D: r_len[3]   <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!r_in.last_char || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_ctl.fire = w_fire;
    assign w_ctl.last = r_in.last_char;

    assign n_window = {r_in.base_char, r_window[WIN_W-1:8]};
    assign n_seen   = (r_seen < SEEN_W'(WIN_CHARS)) ? r_seen + 1'b1 : r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && r_in.last_char)) begin
            r_window <= '0;
            r_seen   <= '0;
        end else if (w_fire) begin
            r_window <= n_window;
            r_seen   <= n_seen;
        end
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_lane
        if (k < NUM_MOTIFS) begin : g_used
            trlr_motif_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_window    (n_window),
                .i_seen      (n_seen),
                .i_motif     (r_motif[k]),
                .i_len       (r_len[k]),
                .o_best_next (w_best[k])
            );
        end else begin : g_unused
            assign w_best[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in.last_char) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in.last_char) begin
            r_out.run_a <= 16'(w_best[0]);
            r_out.run_b <= 16'(w_best[1]);
            r_out.run_c <= 16'(w_best[2]);
            r_out.run_d <= 16'(w_best[3]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/trlr_checker.sv =====
// ----------------------------------------------------------------------------
// trlr_checker: port-level checks for the tandem repeat run counter
// Reset, result hold and input backpressure rules seen at the top level.
// ----------------------------------------------------------------------------
module trlr_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input trlr_pkg::t_out_item   o_out_data
);
    import trlr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while result register empty");

endmodule

bind tandem_repeat_longest_run_unit trlr_checker u_trlr_checker (.*);

// ===== sim/tandem_repeat_longest_run_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tandem_repeat_longest_run_unit_tb: self-checking bench for the run counter
// Streams directed and random character sequences, predicts the four
// longest-run counts per sequence and checks each result transfer against
// the prediction, across several motif and length settings.
// ----------------------------------------------------------------------------
module tandem_repeat_longest_run_unit_tb;
    import trlr_pkg::*;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              i_cfg_we = 1'b0;
    t_cfg_index        i_cfg_index = CFG_MOTIF_A;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    tandem_repeat_longest_run_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state and configuration
    t_window          scan_window;
    t_seen            scan_seen;
    logic [SKIP_W-1:0] scan_skip [SLOTS];
    t_run             scan_cur [SLOTS];
    t_run             scan_best [SLOTS];
    t_motif           motif_q [SLOTS];
    t_len             len_q [SLOTS];

    t_in_item         pending_chars [$];
    t_out_item        expected_runs [$];
    logic [7:0]       seq_chars [$];
    logic [CFG_W-1:0] cfg_words [8];
    int               error_count = 0;
    bit               calm = 1'b0;
    string            bases = "ACGT";

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned span(int k);
        int unsigned l;
        l = len_q[k];
        if (l == 0) l = 1;
        if (l > MAX_MOTIF_LEN) l = MAX_MOTIF_LEN;
        return l;
    endfunction

    task automatic clear_scan();
        scan_window = '0;
        scan_seen = '0;
        for (int k = 0; k < SLOTS; k++) begin
            scan_skip[k] = '0;
            scan_cur[k] = '0;
            scan_best[k] = '0;
        end
    endtask

    task automatic scan_char(input t_in_item it);
        int unsigned l;
        t_motif      win, pat;
        t_out_item   res;
        scan_window = {it.base_char, scan_window[WIN_W-1:8]};
        if (scan_seen < WIN_CHARS) scan_seen++;
        for (int k = 0; k < SLOTS; k++) begin
            l = span(k);
            if (k < NUM_MOTIFS && scan_seen >= l) begin
                if (scan_skip[k] != 0) begin
                    scan_skip[k]--;
                end else begin
                    win = scan_window >> (8 * (WIN_CHARS - l));
                    pat = (l >= 8) ? motif_q[k] : motif_q[k] & ((64'd1 << (8 * l)) - 1);
                    if (win == pat) begin
                        if (scan_cur[k] != '1) scan_cur[k]++;
                        if (scan_cur[k] > scan_best[k]) scan_best[k] = scan_cur[k];
                        scan_skip[k] = SKIP_W'(l - 1);
                    end else begin
                        scan_cur[k] = '0;
                        scan_skip[k] = '0;
                    end
                end
            end
        end
        if (it.last_char) begin
            res.run_a = (NUM_MOTIFS > 0) ? scan_best[0] : '0;
            res.run_b = (NUM_MOTIFS > 1) ? scan_best[1] : '0;
            res.run_c = (NUM_MOTIFS > 2) ? scan_best[2] : '0;
            res.run_d = (NUM_MOTIFS > 3) ? scan_best[3] : '0;
            expected_runs.insert(expected_runs.size(), res);
            clear_scan();
        end
    endtask

    task automatic send_sequence();
        t_in_item it;
        foreach (seq_chars[i]) begin
            it.base_char = seq_chars[i];
            it.last_char = (i == seq_chars.size() - 1);
            pending_chars.insert(pending_chars.size(), it);
        end
        seq_chars.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) seq_chars.insert(seq_chars.size(), s[i]);
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_sequence();
    endtask

    function automatic logic [63:0] text_motif(input string s, input logic [63:0] junk);
        logic [63:0] m;
        m = junk;
        for (int i = 0; i < s.len() && i < 8; i++) m[8*i +: 8] = s[i];
        return m;
    endfunction

    task automatic load_motifs();
        t_cfg_index idx;
        idx = idx.first();
        for (int n = 0; n < idx.num(); n++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= cfg_words[idx];
            if (idx < CFG_LENGTH_A) motif_q[idx - CFG_MOTIF_A] = cfg_words[idx];
            else len_q[idx - CFG_LENGTH_A] = cfg_words[idx][LEN_W-1:0];
            idx = idx.next();
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_motifs();
        int r;
        for (int k = 0; k < SLOTS; k++) begin
            r = $urandom_range(99);
            if (r < 6) cfg_words[CFG_LENGTH_A + k] = 0;
            else if (r < 12) cfg_words[CFG_LENGTH_A + k] = 64'($urandom_range(15, 9));
            else if (r < 30) cfg_words[CFG_LENGTH_A + k] = 8;
            else if (r < 45) cfg_words[CFG_LENGTH_A + k] = 1;
            else cfg_words[CFG_LENGTH_A + k] = 64'($urandom_range(8, 1));
            for (int j = 0; j < 8; j++) begin
                cfg_words[CFG_MOTIF_A + k][8*j +: 8] =
                    ($urandom_range(9) < 8) ? bases[$urandom_range(3)]
                                            : 8'($urandom_range(255));
            end
        end
    endtask

    task automatic build_sequence();
        int target, r, k, reps;
        target = ($urandom_range(99) < 10) ? $urandom_range(3, 1) : $urandom_range(30, 4);
        while (seq_chars.size() < target) begin
            r = $urandom_range(99);
            if (r < 60) begin
                k = $urandom_range(SLOTS - 1);
                reps = $urandom_range(6, 1);
                repeat (reps)
                    for (int j = 0; j < span(k); j++)
                        seq_chars.insert(seq_chars.size(), motif_q[k][8*j +: 8]);
            end else if (r < 85) begin
                seq_chars.insert(seq_chars.size(), bases[$urandom_range(3)]);
            end else begin
                seq_chars.insert(seq_chars.size(), 8'($urandom_range(255)));
            end
        end
        while (seq_chars.size() > target) void'(seq_chars.pop_back());
        send_sequence();
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || i_in_valid || expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_chars.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                i_in_data  <= pending_chars.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item   want;
        logic [15:0] w, g;
        string       names [4];
        names = '{"run_a", "run_b", "run_c", "run_d"};
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected result transfer %h", o_out_data);
                    error_count++;
                end else begin
                    want = expected_runs.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        w = want[63 - 16*k -: 16];
                        g = o_out_data[63 - 16*k -: 16];
                        if (w !== g) begin
                            $error("%s expected %0d actual %0d", names[k], w, g);
                            error_count++;
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) scan_char(i_in_data);
        end
    end

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            motif_q[k] = '0;
            len_q[k] = 1;
        end
        clear_scan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every motif is the zero byte
        seq_chars.insert(seq_chars.size(), 8'h00);
        send_sequence();
        seq_chars = '{8'hFF, 8'h00, 8'h00};
        send_sequence();
        drain();

        // length zero reads as one, length above eight reads as eight
        cfg_words[CFG_MOTIF_A]  = text_motif("AC", 64'hA5A5_5A5A_C3C3_0000);
        cfg_words[CFG_MOTIF_B]  = text_motif("ACGTACGT", '0);
        cfg_words[CFG_MOTIF_C]  = 64'hFFFF_FFFF_FFFF_FFFF;
        cfg_words[CFG_MOTIF_D]  = text_motif("GATTACAG", '0);
        cfg_words[CFG_LENGTH_A] = 2;
        cfg_words[CFG_LENGTH_B] = 8;
        cfg_words[CFG_LENGTH_C] = 0;
        cfg_words[CFG_LENGTH_D] = 15;
        load_motifs();
        for (int i = 0; i < 6; i++) seq_chars.insert(seq_chars.size(), bases[i % 2]);
        add_text("ACGTACGT");
        seq_chars.insert(seq_chars.size(), 8'hFF);
        seq_chars.insert(seq_chars.size(), 8'hFF);
        send_sequence();
        send_text("ACA");
        send_text("A");
        drain();

        for (int p = 0; p < 7; p++) begin
            calm = (p == 3);
            pick_motifs();
            load_motifs();
            while (pending_chars.size() < 57) build_sequence();
            drain();
        end
        calm = 1'b0;

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
